>>> rtl/sqvg_pkg.sv
package sqvg_pkg;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [15:0]        rotation;
    logic [15:0]        cell_index;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic               cell_out_of_range;
    logic               last_vertex;
  } out_item_t;

  typedef enum logic [2:0] {
    REG_ATLAS_ENABLE  = 3'd0,
    REG_ATLAS_COLUMNS = 3'd1,
    REG_ATLAS_ROWS    = 3'd2,
    REG_QUAD_WIDTH    = 3'd3,
    REG_QUAD_HEIGHT   = 3'd4,
    REG_PIVOT_X       = 3'd5,
    REG_PIVOT_Y       = 3'd6
  } cfg_reg_t;

  localparam int CORDIC_STEPS = 24;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032875;
  localparam logic [29:0] ATAN_TURNS [CORDIC_STEPS] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
  };

  localparam logic [16:0] UV_ONE    = 17'd65536;
  localparam logic [16:0] PIVOT_ONE = 17'd65536;
  localparam logic [2:0]  VERT_LAST = 3'd5;

  // Corner order of the six vertices: left-top, right-top, left-bottom,
  // right-top, right-bottom, left-bottom. Bit 0 is right, bit 1 is bottom.
  localparam logic [1:0] CORNER_OF [6] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd3, 2'd2};

endpackage

>>> rtl/sprite_quad_vertex_gen_core.sv
// Rotated sprite quad generator with texture atlas UV.
// A request on the input channel (start, in_data) is taken at a clock edge
// where start is high and busy is low. Each request yields six vertices, the
// two triangles of the quad, strobed on out_valid with out_data in
// consecutive cycles; the last one carries last_vertex.
// The datapath is a 34-stage pipeline: an integer divider and four fractional
// dividers for UV, one bit per stage, run beside a one-step-per-stage CORDIC
// and the offset, rotation and saturation stages. A new request may enter
// before the last one has left the pipeline; busy stays high after each
// accepted request so that the single result channel is never overrun.
// Configuration registers are written through cfg_valid, cfg_index and
// cfg_data, always ready, and must only be written while no request is in
// flight. Synchronous reset clears the pipeline valid bits, the output strobe
// and loads the register reset values. The receiver cannot stall, so results
// are never held back.
module sprite_quad_vertex_gen_core #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sqvg_pkg::in_item_t  in_data,
  output logic                out_valid,
  output sqvg_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import sqvg_pkg::*;

  localparam int LAT = 33;

  typedef struct packed {
    logic [15:0] num;
    logic [7:0]  rem;
    logic [15:0] quo;
  } idiv_t;

  typedef struct packed {
    logic [8:0]  rem;
    logic [16:0] quo;
  } fdiv_t;

  typedef struct packed {
    logic signed [32:0] oxl;
    logic signed [32:0] oxr;
    logic signed [32:0] oyt;
    logic signed [32:0] oyb;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic               zero;
  } geo_t;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [31:0] z;
    logic [1:0]         quad;
  } cord_t;

  typedef struct packed {
    logic [3:0][31:0] x;
    logic [3:0][31:0] y;
  } geo_out_t;

  function automatic idiv_t idiv_step(idiv_t p, logic [8:0] d);
    idiv_t      r;
    logic [8:0] t;
    logic       ge;
    t     = {p.rem, p.num[15]};
    ge    = (t >= d);
    t     = ge ? (t - d) : t;
    r.rem = t[7:0];
    r.num = {p.num[14:0], 1'b0};
    r.quo = {p.quo[14:0], ge};
    return r;
  endfunction

  function automatic fdiv_t fdiv_step(fdiv_t p, logic [8:0] d, logic first);
    fdiv_t      r;
    logic [8:0] t;
    logic       ge;
    t     = first ? p.rem : {p.rem[7:0], 1'b0};
    ge    = (t >= d);
    r.rem = ge ? (t - d) : t;
    r.quo = {p.quo[15:0], ge};
    return r;
  endfunction

  function automatic cord_t cord_step(cord_t p, int i);
    cord_t              r;
    logic signed [32:0] xs;
    logic signed [32:0] ys;
    logic signed [31:0] a;
    xs     = p.x >>> i;
    ys     = p.y >>> i;
    a      = $signed({2'b00, ATAN_TURNS[i]});
    r.quad = p.quad;
    if (!p.z[31]) begin
      r.x = p.x - ys;
      r.y = p.y + xs;
      r.z = p.z - a;
    end else begin
      r.x = p.x + ys;
      r.y = p.y - xs;
      r.z = p.z + a;
    end
    return r;
  endfunction

  // Configuration registers.
  logic        atlas_enable_r;
  logic [8:0]  atlas_columns_r;
  logic [8:0]  atlas_rows_r;
  logic [30:0] quad_width_r;
  logic [30:0] quad_height_r;
  logic [16:0] pivot_x_r;
  logic [16:0] pivot_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atlas_enable_r  <= 1'b0;
      atlas_columns_r <= 9'd1;
      atlas_rows_r    <= 9'd1;
      quad_width_r    <= '0;
      quad_height_r   <= '0;
      pivot_x_r       <= 17'd32768;
      pivot_y_r       <= 17'd32768;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ATLAS_ENABLE:  atlas_enable_r  <= cfg_data[0];
        REG_ATLAS_COLUMNS: atlas_columns_r <= cfg_data[8:0];
        REG_ATLAS_ROWS:    atlas_rows_r    <= cfg_data[8:0];
        REG_QUAD_WIDTH:    quad_width_r    <= cfg_data[30:0];
        REG_QUAD_HEIGHT:   quad_height_r   <= cfg_data[30:0];
        REG_PIVOT_X:       pivot_x_r       <= cfg_data[16:0];
        REG_PIVOT_Y:       pivot_y_r       <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  logic [8:0]  cols;
  logic [8:0]  rows;
  logic [16:0] px;
  logic [16:0] py;

  assign cols = (atlas_columns_r == 9'd0) ? 9'd1 :
                (atlas_columns_r > 9'd256) ? 9'd256 : atlas_columns_r;
  assign rows = (atlas_rows_r == 9'd0) ? 9'd1 :
                (atlas_rows_r > 9'd256) ? 9'd256 : atlas_rows_r;
  assign px   = (pivot_x_r > PIVOT_ONE) ? PIVOT_ONE : pivot_x_r;
  assign py   = (pivot_y_r > PIVOT_ONE) ? PIVOT_ONE : pivot_y_r;

  // Request acceptance and pacing.
  logic       accept;
  logic [2:0] gap_r;
  logic [LAT:0] vld_r;
  in_item_t   in_r;

  assign accept = start && !busy;
  assign busy   = (gap_r != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= '0;
      vld_r <= '0;
    end else begin
      gap_r <= accept ? VERT_LAST : ((gap_r != 3'd0) ? gap_r - 3'd1 : 3'd0);
      vld_r <= {vld_r[LAT-1:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_data;
  end

  // Cell split into row and column.
  idiv_t idv_r [16];
  idiv_t idv_init;

  assign idv_init = '{num: in_r.cell_index, rem: 8'd0, quo: 16'd0};

  always_ff @(posedge clk) begin
    idv_r[0] <= idiv_step(idv_init, cols);
    for (int j = 1; j < 16; j++) begin
      idv_r[j] <= idiv_step(idv_r[j-1], cols);
    end
  end

  // Four fractional dividers: u left, u right, v top, v bottom.
  logic [15:0] row;
  logic [7:0]  col;
  logic        row_ok;
  fdiv_t       fr_init [4];
  logic [8:0]  fr_div [4];
  fdiv_t       fr_r [17][4];
  logic [16:0] fl_r;

  assign row    = idv_r[15].quo;
  assign col    = idv_r[15].rem;
  assign row_ok = (row < {7'd0, rows});

  always_comb begin
    fr_init[0] = '{rem: {1'b0, col}, quo: 17'd0};
    fr_init[1] = '{rem: {1'b0, col} + 9'd1, quo: 17'd0};
    fr_init[2] = '{rem: row_ok ? {1'b0, row[7:0]} : 9'd0, quo: 17'd0};
    fr_init[3] = '{rem: row_ok ? ({1'b0, row[7:0]} + 9'd1) : 9'd0, quo: 17'd0};
    fr_div[0]  = cols;
    fr_div[1]  = cols;
    fr_div[2]  = rows;
    fr_div[3]  = rows;
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      fr_r[0][l] <= fdiv_step(fr_init[l], fr_div[l], 1'b1);
      for (int j = 1; j < 17; j++) begin
        fr_r[j][l] <= fdiv_step(fr_r[j-1][l], fr_div[l], 1'b0);
      end
    end
    fl_r <= {fl_r[15:0], atlas_enable_r && !row_ok};
  end

  // Pivot split and corner offsets.
  logic [ANGLE_BITS-1:0] angle;
  logic [31:0]           phase;

  generate
    if (ANGLE_BITS <= 16) begin : g_ang_narrow
      assign angle = in_r.rotation[ANGLE_BITS-1:0];
    end else begin : g_ang_wide
      assign angle = {{(ANGLE_BITS-16){1'b0}}, in_r.rotation};
    end
  endgenerate

  assign phase = {angle, {(32-ANGLE_BITS){1'b0}}};

  logic [47:0]        g1_prod_w_r;
  logic [47:0]        g1_prod_h_r;
  logic               g1_zero_r;
  logic [31:0]        g1_phase_r;
  logic signed [31:0] g1_cx_r;
  logic signed [31:0] g1_cy_r;

  always_ff @(posedge clk) begin
    g1_prod_w_r <= {17'd0, quad_width_r} * {31'd0, px};
    g1_prod_h_r <= {17'd0, quad_height_r} * {31'd0, py};
    g1_zero_r   <= (angle == '0);
    g1_phase_r  <= phase;
    g1_cx_r     <= in_r.center_x;
    g1_cy_r     <= in_r.center_y;
  end

  logic [31:0] w_inc;
  logic [31:0] h_inc;
  logic [47:0] w_rnd;
  logic [47:0] h_rnd;
  logic [30:0] wl;
  logic [30:0] hl;
  geo_t        geo_init;

  always_comb begin
    w_inc = {1'b0, quad_width_r} + 32'd1;
    h_inc = {1'b0, quad_height_r} + 32'd1;
    w_rnd = g1_prod_w_r + 48'd32768;
    h_rnd = g1_prod_h_r + 48'd32768;
    wl    = g1_zero_r ? w_inc[31:1] : w_rnd[46:16];
    hl    = g1_zero_r ? h_inc[31:1] : h_rnd[46:16];
    geo_init.oxl  = -$signed({2'b00, wl});
    geo_init.oxr  = $signed({2'b00, quad_width_r}) - $signed({2'b00, wl});
    geo_init.oyt  = $signed({2'b00, quad_height_r}) - $signed({2'b00, hl});
    geo_init.oyb  = -$signed({2'b00, hl});
    geo_init.cx   = g1_cx_r;
    geo_init.cy   = g1_cy_r;
    geo_init.zero = g1_zero_r;
  end

  // CORDIC, one rotation step per stage.
  geo_t  gp_r [25];
  cord_t cd_r [25];

  always_ff @(posedge clk) begin
    gp_r[0] <= geo_init;
    cd_r[0] <= '{x: CORDIC_GAIN, y: 33'sd0, z: $signed({2'b00, g1_phase_r[29:0]}),
                 quad: g1_phase_r[31:30]};
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      cd_r[i+1] <= cord_step(cd_r[i], i);
      gp_r[i+1] <= gp_r[i];
    end
  end

  // Quadrant fold.
  logic signed [32:0] cs_c_r;
  logic signed [32:0] cs_s_r;
  geo_t               gq_r;

  always_ff @(posedge clk) begin
    case (cd_r[24].quad)
      2'd0: begin
        cs_c_r <= cd_r[24].x;
        cs_s_r <= cd_r[24].y;
      end
      2'd1: begin
        cs_c_r <= -cd_r[24].y;
        cs_s_r <= cd_r[24].x;
      end
      2'd2: begin
        cs_c_r <= -cd_r[24].x;
        cs_s_r <= -cd_r[24].y;
      end
      default: begin
        cs_c_r <= cd_r[24].y;
        cs_s_r <= -cd_r[24].x;
      end
    endcase
    gq_r <= gp_r[24];
  end

  // Rotation products; index 0 is left or top, 1 is right or bottom.
  logic signed [65:0] oxc_r [2];
  logic signed [65:0] oxs_r [2];
  logic signed [65:0] oyc_r [2];
  logic signed [65:0] oys_r [2];
  geo_t               gm_r;

  always_ff @(posedge clk) begin
    oxc_r[0] <= gq_r.oxl * cs_c_r;
    oxc_r[1] <= gq_r.oxr * cs_c_r;
    oxs_r[0] <= gq_r.oxl * cs_s_r;
    oxs_r[1] <= gq_r.oxr * cs_s_r;
    oyc_r[0] <= gq_r.oyt * cs_c_r;
    oyc_r[1] <= gq_r.oyb * cs_c_r;
    oys_r[0] <= gq_r.oyt * cs_s_r;
    oys_r[1] <= gq_r.oyb * cs_s_r;
    gm_r     <= gq_r;
  end

  logic signed [36:0] vx_nxt [4];
  logic signed [36:0] vy_nxt [4];
  logic signed [36:0] vx_r [4];
  logic signed [36:0] vy_r [4];
  logic signed [31:0] gv_cx_r;
  logic signed [31:0] gv_cy_r;

  always_comb begin
    logic signed [66:0] ax;
    logic signed [66:0] ay;
    logic signed [32:0] ox;
    logic signed [32:0] oy;
    for (int k = 0; k < 4; k++) begin
      ax = 67'(oxc_r[k%2]) - 67'(oys_r[k/2]) + 67'sd536870912;
      ay = 67'(oxs_r[k%2]) + 67'(oyc_r[k/2]) + 67'sd536870912;
      ax = ax >>> 30;
      ay = ay >>> 30;
      ox = (k % 2 == 1) ? gm_r.oxr : gm_r.oxl;
      oy = (k / 2 == 1) ? gm_r.oyb : gm_r.oyt;
      vx_nxt[k] = gm_r.zero ? 37'(ox) : ax[36:0];
      vy_nxt[k] = gm_r.zero ? 37'(oy) : ay[36:0];
    end
  end

  always_ff @(posedge clk) begin
    vx_r    <= vx_nxt;
    vy_r    <= vy_nxt;
    gv_cx_r <= gm_r.cx;
    gv_cy_r <= gm_r.cy;
  end

  // Anchor add with saturation, then alignment with the UV path.
  geo_out_t gf_nxt;
  geo_out_t gf_r [4];

  always_comb begin
    logic signed [37:0] sx;
    logic signed [37:0] sy;
    for (int k = 0; k < 4; k++) begin
      sx = 38'(gv_cx_r) + 38'(vx_r[k]);
      sy = 38'(gv_cy_r) + 38'(vy_r[k]);
      if (sx > 38'sd2147483647) gf_nxt.x[k] = 32'h7fff_ffff;
      else if (sx < -38'sd2147483648) gf_nxt.x[k] = 32'h8000_0000;
      else gf_nxt.x[k] = sx[31:0];
      if (sy > 38'sd2147483647) gf_nxt.y[k] = 32'h7fff_ffff;
      else if (sy < -38'sd2147483648) gf_nxt.y[k] = 32'h8000_0000;
      else gf_nxt.y[k] = sy[31:0];
    end
  end

  always_ff @(posedge clk) begin
    gf_r[0] <= gf_nxt;
    for (int j = 1; j < 4; j++) begin
      gf_r[j] <= gf_r[j-1];
    end
  end

  // Vertex sequencer.
  geo_out_t  hold_geo_r;
  logic [16:0] hold_ul_r;
  logic [16:0] hold_ur_r;
  logic [16:0] hold_vt_r;
  logic [16:0] hold_vb_r;
  logic        hold_flag_r;
  logic [2:0]  seq_cnt_r;
  logic        seq_act_r;
  logic        out_valid_r;
  out_item_t   out_data_r;
  logic [1:0]  cn;

  assign cn = CORNER_OF[seq_cnt_r];

  always_ff @(posedge clk) begin
    if (vld_r[LAT]) begin
      hold_geo_r  <= gf_r[3];
      hold_ul_r   <= atlas_enable_r ? fr_r[16][0].quo : 17'd0;
      hold_ur_r   <= atlas_enable_r ? fr_r[16][1].quo : UV_ONE;
      hold_vt_r   <= !atlas_enable_r ? 17'd0 : (fl_r[16] ? UV_ONE : fr_r[16][2].quo);
      hold_vb_r   <= !atlas_enable_r ? UV_ONE : (fl_r[16] ? UV_ONE : fr_r[16][3].quo);
      hold_flag_r <= fl_r[16];
    end
    out_data_r.vert_x            <= hold_geo_r.x[cn];
    out_data_r.vert_y            <= hold_geo_r.y[cn];
    out_data_r.tex_u             <= cn[0] ? hold_ur_r : hold_ul_r;
    out_data_r.tex_v             <= cn[1] ? hold_vb_r : hold_vt_r;
    out_data_r.cell_out_of_range <= hold_flag_r;
    out_data_r.last_vertex       <= (seq_cnt_r == VERT_LAST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_cnt_r   <= '0;
      seq_act_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= seq_act_r;
      if (vld_r[LAT]) begin
        seq_cnt_r <= '0;
        seq_act_r <= 1'b1;
      end else if (seq_act_r) begin
        seq_cnt_r <= seq_cnt_r + 3'd1;
        if (seq_cnt_r == VERT_LAST) begin
          seq_act_r <= 1'b0;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted request");

  a_quad_not_cut: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAT] |-> (!seq_act_r || seq_cnt_r == VERT_LAST))
    else $error("new quad arrived while the previous one was being emitted");

  a_six_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_vertex) |-> $past(out_valid, 5))
    else $error("last vertex strobed without five vertices before it");

endmodule

>>> bench/testbench.sv
module testbench;
  import sqvg_pkg::*;

  localparam int LATENCY = 48;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_data = '0;
  logic        out_valid;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Testbench copy of the configuration registers.
  logic        atlas_on;
  logic [8:0]  atlas_cols;
  logic [8:0]  atlas_rows;
  logic [30:0] quad_w;
  logic [30:0] quad_h;
  logic [16:0] piv_x;
  logic [16:0] piv_y;

  out_item_t vertex_queue[$];
  int        mismatches = 0;
  int        send_idle_pct = 0;

  localparam longint ATAN_LUT [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  always #2 clk = ~clk;

  sprite_quad_vertex_gen_core i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  task automatic rotate_unit(input logic [31:0] phase, output longint c,
                             output longint s);
    longint x, y, z, xs, ys;
    x = 652032875;
    y = 0;
    z = phase[29:0];
    for (int i = 0; i < 24; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= ATAN_LUT[i];
      end else begin
        x += ys; y -= xs; z += ATAN_LUT[i];
      end
    end
    case (phase[31:30])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  task automatic predict_quad(input in_item_t it);
    longint w, h, wl, hl, c, s, cols, rows, col, row, cell_no;
    longint ox[4], oy[4], vx[4], vy[4];
    longint ul, ur, vt, vb, px, py;
    logic flag;
    int cn;
    out_item_t v;
    w = quad_w; h = quad_h;
    px = (piv_x > 65536) ? 65536 : piv_x;
    py = (piv_y > 65536) ? 65536 : piv_y;
    ul = 0; ur = 65536; vt = 0; vb = 65536; flag = 1'b0;
    if (atlas_on) begin
      cols = (atlas_cols == 0) ? 1 : (atlas_cols > 256 ? 256 : atlas_cols);
      rows = (atlas_rows == 0) ? 1 : (atlas_rows > 256 ? 256 : atlas_rows);
      cell_no = it.cell_index;
      col = cell_no % cols; row = cell_no / cols;
      ul = col * 65536 / cols; ur = (col + 1) * 65536 / cols;
      vt = row * 65536 / rows; vb = (row + 1) * 65536 / rows;
      flag = row >= rows;
      if (vt > 65536) vt = 65536;
      if (vb > 65536) vb = 65536;
    end
    if (it.rotation == 0) begin
      wl = (w + 1) >> 1; hl = (h + 1) >> 1;
    end else begin
      wl = (w * px + 32768) >> 16; hl = (h * py + 32768) >> 16;
    end
    ox[0] = -wl; oy[0] = h - hl; ox[1] = w - wl; oy[1] = h - hl;
    ox[2] = -wl; oy[2] = -hl; ox[3] = w - wl; oy[3] = -hl;
    if (it.rotation == 0) begin
      for (int k = 0; k < 4; k++) begin
        vx[k] = ox[k]; vy[k] = oy[k];
      end
    end else begin
      rotate_unit({it.rotation, 16'h0}, c, s);
      for (int k = 0; k < 4; k++) begin
        vx[k] = floor_shr(ox[k] * c - oy[k] * s + (64'sd1 <<< 29), 30);
        vy[k] = floor_shr(ox[k] * s + oy[k] * c + (64'sd1 <<< 29), 30);
      end
    end
    for (int k = 0; k < 6; k++) begin
      cn = CORNER_OF[k];
      v.vert_x = clip32(longint'(it.center_x) + vx[cn]);
      v.vert_y = clip32(longint'(it.center_y) + vy[cn]);
      v.tex_u = (cn[0] == 1'b0) ? ul[16:0] : ur[16:0];
      v.tex_v = (cn[1] == 1'b0) ? vt[16:0] : vb[16:0];
      v.cell_out_of_range = flag;
      v.last_vertex = (k == 5);
      vertex_queue.push_back(v);
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid) begin
      if (vertex_queue.size() == 0) begin
        report_mismatch("vertex with no expectation");
      end else begin
        e = vertex_queue.pop_front();
        if (out_data.vert_x !== e.vert_x)
          report_mismatch($sformatf("vert_x %h exp %h", out_data.vert_x, e.vert_x));
        if (out_data.vert_y !== e.vert_y)
          report_mismatch($sformatf("vert_y %h exp %h", out_data.vert_y, e.vert_y));
        if (out_data.tex_u !== e.tex_u)
          report_mismatch($sformatf("tex_u %h exp %h", out_data.tex_u, e.tex_u));
        if (out_data.tex_v !== e.tex_v)
          report_mismatch($sformatf("tex_v %h exp %h", out_data.tex_v, e.tex_v));
        if (out_data.cell_out_of_range !== e.cell_out_of_range)
          report_mismatch("cell_out_of_range differs");
        if (out_data.last_vertex !== e.last_vertex)
          report_mismatch("last_vertex differs");
      end
    end
  end

  task automatic send_request(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_quad(it);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ATLAS_ENABLE:  atlas_on = val[0];
      REG_ATLAS_COLUMNS: atlas_cols = val[8:0];
      REG_ATLAS_ROWS:    atlas_rows = val[8:0];
      REG_QUAD_WIDTH:    quad_w = val[30:0];
      REG_QUAD_HEIGHT:   quad_h = val[30:0];
      REG_PIVOT_X:       piv_x = val[16:0];
      default:           piv_y = val[16:0];
    endcase
  endtask

  task automatic drain;
    start <= 1'b0;
    in_data <= '0;
    while (vertex_queue.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic setup(input logic en, input logic [8:0] c, input logic [8:0] r,
                       input logic [30:0] w, input logic [30:0] h,
                       input logic [16:0] x, input logic [16:0] y);
    drain();
    write_reg(REG_ATLAS_ENABLE, en);
    write_reg(REG_ATLAS_COLUMNS, c);
    write_reg(REG_ATLAS_ROWS, r);
    write_reg(REG_QUAD_WIDTH, w);
    write_reg(REG_QUAD_HEIGHT, h);
    write_reg(REG_PIVOT_X, x);
    write_reg(REG_PIVOT_Y, y);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t rand_item();
    in_item_t it;
    it.center_x = $urandom();
    it.center_y = $urandom();
    if ($urandom_range(3) == 0) it.center_x = {$urandom_range(1) ? 2'b01 : 2'b10, 30'h0};
    it.rotation = ($urandom_range(7) == 0) ? 16'h0 : 16'($urandom());
    it.cell_index = ($urandom_range(1)) ? 16'($urandom_range(300)) : 16'($urandom());
    return it;
  endfunction

  task automatic test_directed;
    in_item_t it;
    setup(1'b0, 9'd1, 9'd1, 31'h0001_0000, 31'h0002_0000, 17'd32768, 17'd32768);
    it = '{32'sd0, 32'sd0, 16'd0, 16'd0};
    send_request(it);
    it = '{32'h7fffffff, 32'h80000000, 16'h4000, 16'hffff};
    send_request(it);
    it = '{32'h80000000, 32'h7fffffff, 16'hffff, 16'd5};
    send_request(it);
    for (int b = 0; b < 16; b++) begin
      it = '{32'sd100, -32'sd100, 16'd1 << b, 16'd0};
      send_request(it);
    end
    setup(1'b1, 9'd4, 9'd2, 31'h7fffffff, 31'h7fffffff, 17'd65536, 17'd0);
    it = '{32'sd0, 32'sd0, 16'd8, 16'd7};
    send_request(it);
    it = '{32'sd0, 32'sd0, 16'h8000, 16'hffff};
    send_request(it);
    setup(1'b1, 9'd0, 9'd511, 31'h0, 31'h7fffffff, 17'h1ffff, 17'h1ffff);
    it = '{32'sd5, 32'sd5, 16'h2000, 16'd255};
    send_request(it);
    it = '{32'sd5, 32'sd5, 16'h0, 16'd256};
    send_request(it);
    setup(1'b1, 9'd256, 9'd256, 31'h0003_8000, 31'h0001_0001, 17'd0, 17'd65535);
    it = '{32'sd0, 32'sd0, 16'h1234, 16'hffff};
    send_request(it);
  endtask

  task automatic test_random(input int n, input int idle);
    send_idle_pct = idle;
    setup(1'($urandom()), 9'($urandom()), 9'($urandom_range(1, 16)),
          31'($urandom_range(0, 32'h0040_0000)), 31'($urandom()),
          17'($urandom_range(0, 70000)), 17'($urandom_range(0, 70000)));
    repeat (n) send_request(rand_item());
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    atlas_on = 0; atlas_cols = 1; atlas_rows = 1;
    quad_w = 0; quad_h = 0; piv_x = 32768; piv_y = 32768;
    @(posedge clk);
    test_directed();
    test_random(50, 0);
    test_random(50, 81);
    test_random(50, 0);
    test_random(50, 10);
    test_random(40, 81);
    test_random(40, 0);
    drain();
    if (mismatches == 0 && vertex_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
